// File: rtl/pce_pkg.sv
// Package: constants, payload structs and shared types for the capacity estimator.
package pce_pkg;

  localparam int NumPortsDef    = 16;
  localparam int CounterBitsDef = 48;
  localparam int RateBitsDef    = 40;
  localparam int PortW          = 4;
  localparam int QueueW         = 32;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 32;

  localparam logic [4:0]  ShiftRst   = 5'd6;
  localparam logic [7:0]  PersistRst = 8'd3;
  localparam logic [15:0] RatioRst   = 16'd55706;
  localparam logic [31:0] BacklogRst = 32'd0;

  localparam logic [CfgIdxW-1:0] RegShift   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPersist = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRatio   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBacklog = 2'd3;

  localparam logic ActRegister = 1'b0;
  localparam logic ActSample   = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  port;
    logic [47:0] busy_time_ns;
    logic [47:0] departed_bytes;
    logic [31:0] queue_bytes;
    logic [39:0] nominal_rate;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  port_out;
    logic [39:0] residual_rate;
    logic        degraded;
    logic        sample_used;
  } out_beat_t;

endpackage

// File: rtl/port_capacity_ewma_estimator_core.sv
// Top level: per-port EWMA drain-rate estimator with persistence filter.
//
// Input channel in_valid/in_stall carries one in_beat_t; output channel
// out_valid/out_stall carries one out_beat_t per accepted beat.
// Configuration: cfg_we with cfg_idx and cfg_data; the user must see
// that it is taken only while idle, as the block does not enforce it.
// A register beat, an out-of-range port or a sample on an unregistered
// port shows its result from READ, a gated-off sample from UPDATE after
// READ; with no stall the next beat is taken once the result has left
// the output register. A sample that passes the backlog gate runs a
// shift-add multiply by 8e9 and a restoring division one bit a cycle
// over the product width, then the EWMA and filter update; its result
// is registered in DONE, and the next beat is taken once it has left
// the output register.
// One beat is in flight at a time; in_stall is high while busy and while
// a result waits in the output register.
// Reset clears all port valid bits and loads the register defaults;
// per-port stores are undefined until a register beat writes them.
// When the receiver stalls the result holds in the output register and
// the next beat is not taken until the result has left it.
module port_capacity_ewma_estimator_core #(
  parameter int NUM_PORTS    = pce_pkg::NumPortsDef,
  parameter int COUNTER_BITS = pce_pkg::CounterBitsDef,
  parameter int RATE_BITS    = pce_pkg::RateBitsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pce_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pce_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [pce_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [pce_pkg::CfgDataW-1:0]   cfg_data
);
  localparam int IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  typedef enum logic [2:0] {IDLE, READ, WAIT_DIV, UPDATE, DONE} state_t;

  logic [4:0]  ewma_shift;
  logic [7:0]  persist_windows;
  logic [15:0] degrade_ratio_q16;
  logic [31:0] backlog_threshold;

  logic [NUM_PORTS-1:0]    port_valid;
  logic [COUNTER_BITS-1:0] last_busy     [NUM_PORTS];
  logic [COUNTER_BITS-1:0] last_bytes    [NUM_PORTS];
  logic [RATE_BITS-1:0]    rate_estimate [NUM_PORTS];
  logic [RATE_BITS-1:0]    nominal       [NUM_PORTS];
  logic [7:0]              low_run       [NUM_PORTS];
  logic                    degraded_flag [NUM_PORTS];

  state_t                  state;
  pce_pkg::in_beat_t       item;
  logic [IdxW-1:0]         idx;
  logic [COUNTER_BITS-1:0] dbusy, dbytes;
  logic [RATE_BITS-1:0]    est, nom;
  logic [7:0]              run;
  logic                    deg;
  logic                    div_start, div_done;
  logic [RATE_BITS-1:0]    div_rate;

  logic [RATE_BITS-1:0]    est_new, diff_up, diff_dn;
  logic [RATE_BITS+15:0]   lhs, rhs;
  logic                    is_low;
  logic [7:0]              run_inc;

  pce_divider #(.CounterBits(COUNTER_BITS), .RateBits(RATE_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .bytes(dbytes), .busy(dbusy),
    .done(div_done), .rate(div_rate)
  );

  assign in_stall = (state != IDLE) || out_valid;

  always_comb begin
    diff_up = (div_rate - est) >> ewma_shift;
    diff_dn = (est - div_rate) >> ewma_shift;
    est_new = (div_rate >= est) ? est + diff_up : est - diff_dn;
    lhs     = {est_new, 16'd0};
    rhs     = (RATE_BITS + 16)'(nom) * (RATE_BITS + 16)'(degrade_ratio_q16);
    is_low  = (nom != '0) && (lhs < rhs);
    run_inc = (run < persist_windows) ? run + 8'd1 : run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_shift        <= pce_pkg::ShiftRst;
      persist_windows   <= pce_pkg::PersistRst;
      degrade_ratio_q16 <= pce_pkg::RatioRst;
      backlog_threshold <= pce_pkg::BacklogRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        pce_pkg::RegShift:   ewma_shift        <= cfg_data[4:0];
        pce_pkg::RegPersist: persist_windows   <= cfg_data[7:0];
        pce_pkg::RegRatio:   degrade_ratio_q16 <= cfg_data[15:0];
        pce_pkg::RegBacklog: backlog_threshold <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      port_valid <= '0;
      div_start  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid && !in_stall) begin
            item  <= in_data;
            idx   <= IdxW'(in_data.port);
            state <= READ;
          end
        end
        READ: begin
          out_data.port_out      <= item.port;
          out_data.degraded      <= 1'b0;
          out_data.sample_used   <= 1'b0;
          if (32'(item.port) >= NUM_PORTS) begin
            out_data.residual_rate <= '0;
            out_valid <= 1'b1;
            state     <= IDLE;
          end else if (item.action == pce_pkg::ActRegister) begin
            port_valid[idx]    <= 1'b1;
            nominal[idx]       <= RATE_BITS'(item.nominal_rate);
            rate_estimate[idx] <= RATE_BITS'(item.nominal_rate);
            last_busy[idx]     <= COUNTER_BITS'(item.busy_time_ns);
            last_bytes[idx]    <= COUNTER_BITS'(item.departed_bytes);
            low_run[idx]       <= 8'd0;
            degraded_flag[idx] <= 1'b0;
            out_data.residual_rate <= 40'(RATE_BITS'(item.nominal_rate));
            out_valid <= 1'b1;
            state     <= IDLE;
          end else if (!port_valid[idx]) begin
            out_data.residual_rate <= '0;
            out_valid <= 1'b1;
            state     <= IDLE;
          end else begin
            dbusy  <= COUNTER_BITS'(item.busy_time_ns) - last_busy[idx];
            dbytes <= COUNTER_BITS'(item.departed_bytes) - last_bytes[idx];
            last_busy[idx]  <= COUNTER_BITS'(item.busy_time_ns);
            last_bytes[idx] <= COUNTER_BITS'(item.departed_bytes);
            est   <= rate_estimate[idx];
            nom   <= nominal[idx];
            run   <= low_run[idx];
            deg   <= degraded_flag[idx];
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if ((item.queue_bytes > backlog_threshold) && (dbusy != '0)) begin
            div_start <= 1'b1;
            state     <= WAIT_DIV;
          end else begin
            out_data.residual_rate <= (nom == '0) ? '0 : 40'(est);
            out_data.degraded      <= deg;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        WAIT_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            rate_estimate[idx] <= est_new;
            est <= est_new;
            if (is_low) begin
              low_run[idx] <= run_inc;
              if (run_inc >= persist_windows) deg <= 1'b1;
              if (run_inc >= persist_windows) degraded_flag[idx] <= 1'b1;
            end else begin
              low_run[idx]       <= 8'd0;
              degraded_flag[idx] <= 1'b0;
              deg <= 1'b0;
            end
            state <= DONE;
          end
        end
        DONE: begin
          out_data.residual_rate <= (nom == '0) ? '0 : 40'(est);
          out_data.degraded      <= deg;
          out_data.sample_used   <= 1'b1;
          out_valid <= 1'b1;
          state     <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/pce_divider.sv
// Bit-serial divider: floor(bytes * 8e9 / busy), saturated to the rate width.
module pce_divider #(
  parameter int CounterBits = pce_pkg::CounterBitsDef,
  parameter int RateBits    = pce_pkg::RateBitsDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CounterBits-1:0] bytes,
  input  logic [CounterBits-1:0] busy,
  output logic                   done,
  output logic [RateBits-1:0]    rate
);
  localparam int ScaleW = 33;
  localparam logic [ScaleW-1:0] Scale = 33'd8000000000;
  localparam int ProdW  = CounterBits + ScaleW;
  localparam int CntW   = $clog2(ProdW + 1);

  typedef enum logic [1:0] {IDLE, MUL, DIV} state_t;

  state_t                state;
  logic [ProdW-1:0]      prod;
  logic [ProdW-1:0]      mcand;
  logic [ScaleW-1:0]     mplier;
  logic [CounterBits:0]  rem;
  logic [CounterBits-1:0] divisor;
  logic [RateBits-1:0]   quot;
  logic                  sat;
  logic [CntW-1:0]       cnt;

  logic [CounterBits:0]  rem_sh;
  logic                  ge;
  logic [CounterBits:0]  rem_sub;

  assign rem_sh  = {rem[CounterBits-1:0], prod[ProdW-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          done <= 1'b0;
          if (start) begin
            prod    <= '0;
            mcand   <= ProdW'(bytes);
            mplier  <= Scale;
            divisor <= busy;
            rem     <= '0;
            quot    <= '0;
            sat     <= 1'b0;
            cnt     <= CntW'(ScaleW);
            state   <= MUL;
          end
        end
        MUL: begin
          done <= 1'b0;
          if (mplier[0]) prod <= prod + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == CntW'(1)) begin
            cnt   <= CntW'(ProdW);
            state <= DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        DIV: begin
          prod <= prod << 1;
          rem  <= ge ? rem_sub : rem_sh;
          if (ge && (cnt > CntW'(RateBits))) sat <= 1'b1;
          quot <= {quot[RateBits-2:0], ge};
          cnt  <= cnt - 1'b1;
          done <= (cnt == CntW'(1));
          if (cnt == CntW'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

  assign rate = sat ? '1 : quot;

endmodule

// File: dv/tb_port_capacity_ewma_estimator_core.sv
// Testbench: per-port capacity estimator checked beat by beat against an EWMA/persistence predictor.
`timescale 1ns / 100ps

module tb_port_capacity_ewma_estimator_core;

  localparam logic [39:0] RateMax = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] CntMax  = 48'hFFFF_FFFF_FFFF;
  localparam int WatchLimit = 5000;
  localparam int SettleCycles = 150;
  localparam int IdxW = pce_pkg::CfgIdxW;

  class capacity_scoreboard;
    logic [4:0]  shift;
    logic [7:0]  persist;
    logic [15:0] ratio;
    logic [31:0] backlog;
    logic        valid [16];
    logic [47:0] busy_snap [16];
    logic [47:0] bytes_snap [16];
    logic [39:0] estimate [16];
    logic [39:0] nominal [16];
    logic [7:0]  low_run [16];
    logic        degr [16];
    pce_pkg::out_beat_t expected_q[$];
    int          errors;

    function new();
      shift = pce_pkg::ShiftRst;
      persist = pce_pkg::PersistRst;
      ratio = pce_pkg::RatioRst;
      backlog = pce_pkg::BacklogRst;
      foreach (valid[i]) valid[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [31:0] val);
      case (idx)
        pce_pkg::RegShift:   shift = val[4:0];
        pce_pkg::RegPersist: persist = val[7:0];
        pce_pkg::RegRatio:   ratio = val[15:0];
        pce_pkg::RegBacklog: backlog = val;
        default: ;
      endcase
    endfunction

    function void note_input(pce_pkg::in_beat_t b);
      pce_pkg::out_beat_t e;
      int          p;
      logic [47:0] dbusy, dbytes;
      logic [127:0] quot;
      logic [39:0] rate, est;
      logic        used;
      e = '0;
      p = int'(b.port);
      e.port_out = b.port;
      used = 1'b0;
      if (b.action == pce_pkg::ActRegister) begin
        valid[p] = 1'b1;
        nominal[p] = b.nominal_rate;
        estimate[p] = b.nominal_rate;
        busy_snap[p] = b.busy_time_ns;
        bytes_snap[p] = b.departed_bytes;
        low_run[p] = 8'd0;
        degr[p] = 1'b0;
      end else begin
        if (!valid[p]) begin
          expected_q.push_back(e);
          return;
        end
        dbusy = b.busy_time_ns - busy_snap[p];
        dbytes = b.departed_bytes - bytes_snap[p];
        busy_snap[p] = b.busy_time_ns;
        bytes_snap[p] = b.departed_bytes;
        if (b.queue_bytes > backlog && dbusy != 0) begin
          quot = ({80'd0, dbytes} * 128'd8000000000) / {80'd0, dbusy};
          rate = (quot > {88'd0, RateMax}) ? RateMax : quot[39:0];
          est = estimate[p];
          if (rate >= est) est = est + ((rate - est) >> shift);
          else est = est - ((est - rate) >> shift);
          estimate[p] = est;
          used = 1'b1;
          if (nominal[p] != 0 &&
              ({24'd0, est} << 16) < {48'd0, ratio} * {24'd0, nominal[p]}) begin
            if (low_run[p] < persist) low_run[p]++;
            if (low_run[p] >= persist) degr[p] = 1'b1;
          end else begin
            low_run[p] = 8'd0;
            degr[p] = 1'b0;
          end
        end
      end
      e.residual_rate = (nominal[p] == 0) ? 40'd0 : estimate[p];
      e.degraded = degr[p];
      e.sample_used = used;
      expected_q.push_back(e);
    endfunction

    function void check_result(pce_pkg::out_beat_t a);
      pce_pkg::out_beat_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat port_out=%0d", a.port_out);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.port_out !== e.port_out) begin
        $error("port_out exp %0d got %0d", e.port_out, a.port_out);
        errors++;
      end
      if (a.residual_rate !== e.residual_rate) begin
        $error("residual_rate exp %0d got %0d", e.residual_rate, a.residual_rate);
        errors++;
      end
      if (a.degraded !== e.degraded) begin
        $error("degraded exp %0b got %0b", e.degraded, a.degraded);
        errors++;
      end
      if (a.sample_used !== e.sample_used) begin
        $error("sample_used exp %0b got %0b", e.sample_used, a.sample_used);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pce_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pce_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_idx = pce_pkg::RegShift;
  logic [pce_pkg::CfgDataW-1:0] cfg_data = '0;

  capacity_scoreboard sb = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_count = 0;

  logic        gen_reg [16];
  logic [47:0] gen_busy [16];
  logic [47:0] gen_bytes [16];
  logic [39:0] gen_nom [16];

  port_capacity_ewma_estimator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WatchLimit) begin
        $display("tb_port_capacity_ewma_estimator_core: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic send(pce_pkg::in_beat_t b);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    if (b.action == pce_pkg::ActRegister) begin
      gen_reg[b.port] = 1'b1;
      gen_nom[b.port] = b.nominal_rate;
    end
    if (b.action == pce_pkg::ActRegister || gen_reg[b.port]) begin
      gen_busy[b.port] = b.busy_time_ns;
      gen_bytes[b.port] = b.departed_bytes;
    end
    if ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  task automatic reg_beat(int p, logic [39:0] nom, logic [47:0] busy, logic [47:0] bytes);
    pce_pkg::in_beat_t b;
    b = '0;
    b.action = pce_pkg::ActRegister;
    b.port = 4'(p);
    b.nominal_rate = nom;
    b.busy_time_ns = busy;
    b.departed_bytes = bytes;
    b.queue_bytes = $urandom;
    send(b);
  endtask

  task automatic sample_beat(int p, logic [47:0] dbusy, logic [47:0] dbytes, logic [31:0] q);
    pce_pkg::in_beat_t b;
    b = '0;
    b.action = pce_pkg::ActSample;
    b.port = 4'(p);
    b.busy_time_ns = gen_busy[p] + dbusy;
    b.departed_bytes = gen_bytes[p] + dbytes;
    b.queue_bytes = q;
    b.nominal_rate = 40'({$urandom, $urandom});
    send(b);
  endtask

  // pick a delta of bytes that drains at roughly pct percent of nominal
  task automatic rate_sample(int p, int pct, logic [31:0] q);
    logic [47:0]  dbusy;
    logic [127:0] want;
    dbusy = 48'($urandom_range(1 << 20, 1));
    want = ({88'd0, gen_nom[p]} * pct / 100) * dbusy / 128'd8000000000;
    sample_beat(p, dbusy, want[47:0], q);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(logic [4:0] sh, logic [7:0] pw, logic [15:0] ra, logic [31:0] bl);
    logic [31:0] vals [4];
    vals = '{{27'd0, sh}, {24'd0, pw}, {16'd0, ra}, bl};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= IdxW'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(IdxW'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int n);
    int p, r;
    logic [191:0] raw;
    pce_pkg::in_beat_t b;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(4, 0))
          0: begin gap_pct = 83; stall_pct = 0; end
          1: begin gap_pct = 0; stall_pct = 83; end
          2: begin gap_pct = 7; stall_pct = 7; end
          default: begin gap_pct = 0; stall_pct = 0; end
        endcase
      end
      p = $urandom_range(15, 0);
      r = $urandom_range(99, 0);
      if (r < 10 || (!gen_reg[p] && r < 80)) begin
        reg_beat(p, ($urandom_range(3, 0) == 0) ? 40'({$urandom, $urandom}) :
                 40'd1_000_000_000 * $urandom_range(400, 1), rand48(), rand48());
      end else if (r < 88) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(pce_pkg::in_beat_t)-1:0];
        b.port = 4'(p);
        send(b);
      end else begin
        rate_sample(p, $urandom_range(130, 0),
                    ($urandom_range(9, 0) == 0) ? $urandom_range(2000, 0) : $urandom);
      end
    end
  endtask

  initial begin
    foreach (gen_reg[i]) begin
      gen_reg[i] = 1'b0;
      gen_busy[i] = '0;
      gen_bytes[i] = '0;
      gen_nom[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sample_beat(15, 48'd5, 48'd5, 32'd100);
    reg_beat(0, RateMax, CntMax, CntMax);
    sample_beat(0, 48'd1000, 48'd1000, 32'hFFFF_FFFF);
    sample_beat(0, 48'd1, CntMax, 32'd1);
    sample_beat(0, 48'd0, 48'd50, 32'd10);
    sample_beat(0, 48'd500, 48'd0, 32'd0);
    reg_beat(1, 40'd0, 48'd0, 48'd0);
    sample_beat(1, 48'd100, 48'd1, 32'd5);
    reg_beat(2, 40'd100_000_000_000, 48'h8000_0000_0000, 48'd7);
    for (int i = 0; i < 5; i++) rate_sample(2, 10, 32'd1000);
    rate_sample(2, 120, 32'd1000);
    reg_beat(3, 40'd1, 48'd0, 48'd0);
    sample_beat(3, 48'd8, 48'd1, 32'd1);
    drain_and_settle();

    write_regs(5'd0, 8'd0, 16'd65535, 32'd0);
    reg_beat(4, 40'd10_000_000_000, 48'd0, 48'd0);
    rate_sample(4, 50, 32'd1);
    rate_sample(4, 101, 32'd1);
    random_items(70);
    drain_and_settle();

    write_regs(5'd16, 8'd255, 16'd0, 32'hFFFF_FFFF);
    random_items(40);
    drain_and_settle();

    write_regs(5'd31, 8'd1, 16'd40000, 32'd1000);
    random_items(80);
    drain_and_settle();

    write_regs(5'd3, 8'd5, 16'd60000, $urandom_range(1 << 16, 0));
    random_items(100);
    drain_and_settle();

    write_regs(pce_pkg::ShiftRst, pce_pkg::PersistRst, pce_pkg::RatioRst,
               pce_pkg::BacklogRst);
    random_items(90);

    gap_pct = 0;
    stall_pct = 0;
    drain_and_settle();
    if (sb.errors == 0) begin
      $display("tb_port_capacity_ewma_estimator_core: PASS");
    end else begin
      $display("tb_port_capacity_ewma_estimator_core: FAIL");
    end
    $finish;
  end

endmodule
